[src/rgbhsv_pkg.sv]
package rgbhsv_pkg;

  // hue sector, chosen red first on ties, then green, then blue
  localparam logic [1:0] SEC_RED   = 2'd0;
  localparam logic [1:0] SEC_GREEN = 2'd1;
  localparam logic [1:0] SEC_BLUE  = 2'd2;

  // queue between front and back; depth must be a power of two so the pointers wrap
  localparam int QUEUE_DEPTH    = 2;
  localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CNT_BITS = QUEUE_PTR_BITS + 1;

  // job word: {hue numerator, hue divisor, saturation dividend, max channel}
  // hue numerator and divisor are below 6*2^cb, so they need cb+3 bits
  function automatic int job_width(input int cb);
    return 2 * (cb + 3) + 3 * cb;
  endfunction

endpackage

[src/rgbhsv_if.sv]
interface rgbhsv_pix_if #(
  parameter int CHANNEL_BITS = 8
);
  logic                    valid;
  logic                    ready;
  logic [CHANNEL_BITS-1:0] red;
  logic [CHANNEL_BITS-1:0] green;
  logic [CHANNEL_BITS-1:0] blue;

  modport source (output valid, red, green, blue, input ready);
  modport sink   (input valid, red, green, blue, output ready);
endinterface

interface rgbhsv_hsv_if #(
  parameter int CHANNEL_BITS = 8,
  parameter int HUE_BITS     = 16
);
  logic                    valid;
  logic                    ready;
  logic [HUE_BITS-1:0]     hue;
  logic [CHANNEL_BITS-1:0] saturation;
  logic [CHANNEL_BITS-1:0] brightness;

  modport source (output valid, hue, saturation, brightness, input ready);
  modport sink   (input valid, hue, saturation, brightness, output ready);
endinterface

[src/rgb_to_hsv_core.sv]
// rgb to hsv converter for a pixel stream. Takes one pixel per clock on in_pix
// (red, green, blue, each CHANNEL_BITS wide, all ones meaning full intensity) and
// gives one result per pixel on out_hsv, in order: brightness is the largest
// channel, saturation is floor(full*(max-min)/max) (0 for black), and hue is a
// fraction of a turn with 2^HUE_BITS steps (0 for grey). Both channels use
// valid/ready; a transfer happens when both are high. Sustained rate is one
// pixel per cycle while out_hsv.ready stays high. Each pixel passes through the
// classify register, the two-entry queue and the pipelined long dividers of
// the back end, whose stages each retire one hue bit (while the stage index
// is below HUE_BITS) and one saturation bit (while it is below CHANNEL_BITS).
// The queue lets the classify stage keep taking pixels until the queue is full
// while the divider pipe is held by back-pressure.
module rgb_to_hsv_core #(
  parameter int CHANNEL_BITS = 8,
  parameter int HUE_BITS     = 16
) (
  input  logic         clk,
  input  logic         rst_n,
  rgbhsv_pix_if.sink   in_pix,
  rgbhsv_hsv_if.source out_hsv
);

  localparam int JOB_W = rgbhsv_pkg::job_width(CHANNEL_BITS);

  logic             fq_valid, fq_ready;
  logic [JOB_W-1:0] fq_data;
  logic             qb_valid, qb_ready;
  logic [JOB_W-1:0] qb_data;

  rgbhsv_front #(
    .CHANNEL_BITS (CHANNEL_BITS),
    .JOB_W        (JOB_W)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .pix       (in_pix),
    .job_valid (fq_valid),
    .job_ready (fq_ready),
    .job_data  (fq_data)
  );

  rgbhsv_queue #(
    .WIDTH (JOB_W)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (fq_valid),
    .in_ready  (fq_ready),
    .in_data   (fq_data),
    .out_valid (qb_valid),
    .out_ready (qb_ready),
    .out_data  (qb_data)
  );

  rgbhsv_back #(
    .CHANNEL_BITS (CHANNEL_BITS),
    .HUE_BITS     (HUE_BITS),
    .JOB_W        (JOB_W)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_valid (qb_valid),
    .job_ready (qb_ready),
    .job_data  (qb_data),
    .hsv       (out_hsv)
  );

endmodule

[src/rgbhsv_front.sv]
module rgbhsv_front #(
  parameter int CHANNEL_BITS = 8,
  parameter int JOB_W        = 46
) (
  input  logic             clk,
  input  logic             rst_n,
  rgbhsv_pix_if.sink       pix,
  output logic             job_valid,
  input  logic             job_ready,
  output logic [JOB_W-1:0] job_data
);

  localparam int CB = CHANNEL_BITS;
  localparam int NW = CB + 3;

  logic [CB-1:0]   r, g, b;
  logic [CB-1:0]   hi, lo, diff, p, q;
  logic [1:0]      sec;
  logic [NW-1:0]   d1, d2, d4, d6, base, num;
  logic [2*CB-1:0] sdvd;

  logic             f_v_r, f_v_nxt;
  logic [JOB_W-1:0] f_job_r;
  logic             load, push;

  always_comb begin
    r = pix.red;
    g = pix.green;
    b = pix.blue;
    if (r >= g && r >= b) begin
      sec = rgbhsv_pkg::SEC_RED;
    end else if (g >= b) begin
      sec = rgbhsv_pkg::SEC_GREEN;
    end else begin
      sec = rgbhsv_pkg::SEC_BLUE;
    end
    lo = (r <= g && r <= b) ? r : ((g <= b) ? g : b);
    case (sec)
      rgbhsv_pkg::SEC_RED: begin
        hi = r;
        p  = g;
        q  = b;
      end
      rgbhsv_pkg::SEC_GREEN: begin
        hi = g;
        p  = b;
        q  = r;
      end
      default: begin
        hi = b;
        p  = r;
        q  = g;
      end
    endcase
    diff = hi - lo;
    d1   = NW'(diff);
    d2   = d1 << 1;
    d4   = d1 << 2;
    d6   = d2 + d4;
    case (sec)
      rgbhsv_pkg::SEC_RED:   base = (p >= q) ? '0 : d6;
      rgbhsv_pkg::SEC_GREEN: base = d2;
      default:               base = d4;
    endcase
    // result is never negative, so wrapping arithmetic in nw bits is exact
    num  = base + NW'(p) - NW'(q);
    // full scale times diff, as diff*2^cb - diff
    sdvd = {diff, {CB{1'b0}}} - (2 * CB)'(diff);
  end

  assign pix.ready = !f_v_r || job_ready;
  assign load      = pix.valid && pix.ready;
  assign push      = f_v_r && job_ready;

  always_comb begin
    f_v_nxt = f_v_r;
    if (load) begin
      f_v_nxt = 1'b1;
    end else if (push) begin
      f_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_v_r <= 1'b0;
    end else begin
      f_v_r <= f_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      f_job_r <= {num, d6, sdvd, hi};
    end
  end

  assign job_valid = f_v_r;
  assign job_data  = f_job_r;

endmodule

[src/rgbhsv_queue.sv]
module rgbhsv_queue #(
  parameter int WIDTH = 46
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [WIDTH-1:0] in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [WIDTH-1:0] out_data
);

  localparam int PW = rgbhsv_pkg::QUEUE_PTR_BITS;
  localparam int CW = rgbhsv_pkg::QUEUE_CNT_BITS;
  localparam logic [CW-1:0] FULL_CNT = CW'(rgbhsv_pkg::QUEUE_DEPTH);

  logic [WIDTH-1:0] mem_r [rgbhsv_pkg::QUEUE_DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic             push, pop;

  assign in_ready  = count_r != FULL_CNT;
  assign out_valid = count_r != '0;
  assign out_data  = mem_r[rd_ptr_r];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= in_data;
    end
  end

endmodule

[src/rgbhsv_back.sv]
module rgbhsv_back #(
  parameter int CHANNEL_BITS = 8,
  parameter int HUE_BITS     = 16,
  parameter int JOB_W        = 46
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             job_valid,
  output logic             job_ready,
  input  logic [JOB_W-1:0] job_data,
  rgbhsv_hsv_if.source     hsv
);

  localparam int CB   = CHANNEL_BITS;
  localparam int HB   = HUE_BITS;
  localparam int NW   = CB + 3;
  localparam int NSTG = (HB > CB) ? HB : CB;

  logic [NW-1:0]   job_num, job_hdiv;
  logic [2*CB-1:0] job_sdvd;
  logic [CB-1:0]   job_hi;

  // per-stage inputs, next values and registers of the two long divisions
  logic [NW-1:0] hrem_i [NSTG];
  logic [HB-1:0] hq_i   [NSTG];
  logic [NW-1:0] hdiv_i [NSTG];
  logic [CB-1:0] srem_i [NSTG];
  logic [CB-1:0] slo_i  [NSTG];
  logic [CB-1:0] sq_i   [NSTG];
  logic [CB-1:0] sdiv_i [NSTG];

  logic [NW-1:0] hrem_nxt [NSTG];
  logic [HB-1:0] hq_nxt   [NSTG];
  logic [CB-1:0] srem_nxt [NSTG];
  logic [CB-1:0] slo_nxt  [NSTG];
  logic [CB-1:0] sq_nxt   [NSTG];

  logic [NW-1:0] hrem_r [NSTG];
  logic [HB-1:0] hq_r   [NSTG];
  logic [NW-1:0] hdiv_r [NSTG];
  logic [CB-1:0] srem_r [NSTG];
  logic [CB-1:0] slo_r  [NSTG];
  logic [CB-1:0] sq_r   [NSTG];
  logic [CB-1:0] sdiv_r [NSTG];

  logic [NSTG-1:0] v_r;
  logic            adv;

  assign job_hi   = job_data[CB-1:0];
  assign job_sdvd = job_data[3*CB-1:CB];
  assign job_hdiv = job_data[3*CB+NW-1:3*CB];
  assign job_num  = job_data[3*CB+2*NW-1:3*CB+NW];

  // the whole pipe moves unless a finished result waits at the end
  assign adv       = !v_r[NSTG-1] || hsv.ready;
  assign job_ready = adv;

  for (genvar k = 0; k < NSTG; k++) begin : g_stage
    if (k == 0) begin : g_first
      // both remainders start below their divisors unless the divisor is zero
      assign hrem_i[k] = job_num;
      assign hq_i[k]   = '0;
      assign hdiv_i[k] = job_hdiv;
      assign srem_i[k] = job_sdvd[2*CB-1:CB];
      assign slo_i[k]  = job_sdvd[CB-1:0];
      assign sq_i[k]   = '0;
      assign sdiv_i[k] = job_hi;
    end else begin : g_next
      assign hrem_i[k] = hrem_r[k-1];
      assign hq_i[k]   = hq_r[k-1];
      assign hdiv_i[k] = hdiv_r[k-1];
      assign srem_i[k] = srem_r[k-1];
      assign slo_i[k]  = slo_r[k-1];
      assign sq_i[k]   = sq_r[k-1];
      assign sdiv_i[k] = sdiv_r[k-1];
    end

    if (k < HB) begin : g_hue
      logic [NW:0] ht;
      logic        hge;
      // a zero divisor (grey pixel) yields all zero bits
      assign ht          = {hrem_i[k], 1'b0};
      assign hge         = (hdiv_i[k] != '0) && (ht >= {1'b0, hdiv_i[k]});
      assign hrem_nxt[k] = hge ? NW'(ht - {1'b0, hdiv_i[k]}) : ht[NW-1:0];
      assign hq_nxt[k]   = {hq_i[k][HB-2:0], hge};
    end else begin : g_hue_hold
      assign hrem_nxt[k] = hrem_i[k];
      assign hq_nxt[k]   = hq_i[k];
    end

    if (k < CB) begin : g_sat
      logic [CB:0] st;
      logic        sge;
      // a zero max (black pixel) yields all zero bits
      assign st          = {srem_i[k], slo_i[k][CB-1]};
      assign sge         = (sdiv_i[k] != '0) && (st >= {1'b0, sdiv_i[k]});
      assign srem_nxt[k] = sge ? CB'(st - {1'b0, sdiv_i[k]}) : st[CB-1:0];
      assign slo_nxt[k]  = {slo_i[k][CB-2:0], 1'b0};
      assign sq_nxt[k]   = {sq_i[k][CB-2:0], sge};
    end else begin : g_sat_hold
      assign srem_nxt[k] = srem_i[k];
      assign slo_nxt[k]  = slo_i[k];
      assign sq_nxt[k]   = sq_i[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (adv) begin
      v_r <= {v_r[NSTG-2:0], job_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < NSTG; k++) begin
        hrem_r[k] <= hrem_nxt[k];
        hq_r[k]   <= hq_nxt[k];
        hdiv_r[k] <= hdiv_i[k];
        srem_r[k] <= srem_nxt[k];
        slo_r[k]  <= slo_nxt[k];
        sq_r[k]   <= sq_nxt[k];
        sdiv_r[k] <= sdiv_i[k];
      end
    end
  end

  assign hsv.valid      = v_r[NSTG-1];
  assign hsv.hue        = hq_r[NSTG-1];
  assign hsv.saturation = sq_r[NSTG-1];
  assign hsv.brightness = sdiv_r[NSTG-1];

endmodule

[verif/rgb_to_hsv_core_tb.sv]
module rgb_to_hsv_core_tb;

  localparam int CB          = 8;
  localparam int HB          = 16;
  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 160;
  localparam int DRAIN_WAIT  = 40;

  typedef struct packed {
    logic [HB-1:0] hue;
    logic [CB-1:0] saturation;
    logic [CB-1:0] brightness;
  } hsv_t;

  class hsv_board;
    hsv_t expected_hsv[$];
    int   errors;
    int   pixels;
    int   results;
    int   greys;
    int   blacks;

    function new();
      errors  = 0;
      pixels  = 0;
      results = 0;
      greys   = 0;
      blacks  = 0;
    endfunction

    function hsv_t convert_pixel(logic [CB-1:0] r, logic [CB-1:0] g, logic [CB-1:0] b);
      hsv_t            res;
      logic [1:0]      sector;
      longint unsigned rv;
      longint unsigned gv;
      longint unsigned bv;
      longint unsigned hi;
      longint unsigned lo;
      longint unsigned diff;
      longint unsigned num;
      longint unsigned quo;
      rv = 64'(r);
      gv = 64'(g);
      bv = 64'(b);
      hi = (rv > gv) ? rv : gv;
      hi = (hi > bv) ? hi : bv;
      lo = (rv < gv) ? rv : gv;
      lo = (lo < bv) ? lo : bv;
      diff = hi - lo;
      res.brightness = hi[CB-1:0];
      res.saturation = '0;
      if (hi != 64'd0) begin
        quo = (((64'd1 << CB) - 64'd1) * diff) / hi;
        res.saturation = quo[CB-1:0];
      end
      res.hue = '0;
      if (diff != 64'd0) begin
        // red wins ties, then green
        if (hi == rv) sector = rgbhsv_pkg::SEC_RED;
        else if (hi == gv) sector = rgbhsv_pkg::SEC_GREEN;
        else sector = rgbhsv_pkg::SEC_BLUE;
        case (sector)
          rgbhsv_pkg::SEC_RED: begin
            if (gv >= bv) num = gv - bv;
            else num = 64'd6 * diff - (bv - gv);
          end
          rgbhsv_pkg::SEC_GREEN: begin
            if (bv >= rv) num = 64'd2 * diff + (bv - rv);
            else num = 64'd2 * diff - (rv - bv);
          end
          default: begin
            if (rv >= gv) num = 64'd4 * diff + (rv - gv);
            else num = 64'd4 * diff - (gv - rv);
          end
        endcase
        quo = ((64'd1 << HB) * num) / (64'd6 * diff);
        res.hue = quo[HB-1:0];
      end
      return res;
    endfunction

    function void note_pixel(logic [CB-1:0] r, logic [CB-1:0] g, logic [CB-1:0] b);
      expected_hsv.push_back(convert_pixel(r, g, b));
      pixels++;
      if (r == g && g == b) greys++;
      if (r == 0 && g == 0 && b == 0) blacks++;
    endfunction

    function void check_hsv(logic [HB-1:0] hue, logic [CB-1:0] sat, logic [CB-1:0] val);
      hsv_t exp_hsv;
      results++;
      if (expected_hsv.size() == 0) begin
        $error("result with nothing pending: hue %0d saturation %0d brightness %0d",
               hue, sat, val);
        errors++;
        return;
      end
      exp_hsv = expected_hsv.pop_front();
      if (hue !== exp_hsv.hue) begin
        $error("hue: expected %0d, got %0d", exp_hsv.hue, hue);
        errors++;
      end
      if (sat !== exp_hsv.saturation) begin
        $error("saturation: expected %0d, got %0d", exp_hsv.saturation, sat);
        errors++;
      end
      if (val !== exp_hsv.brightness) begin
        $error("brightness: expected %0d, got %0d", exp_hsv.brightness, val);
        errors++;
      end
    endfunction

    function int pending();
      return expected_hsv.size();
    endfunction
  endclass

  logic clk;
  logic rst_n;
  int   idle_pct;
  int   holds_asked;
  int   holds_started;
  int   hold_left;
  int   cycle_cnt;
  hsv_board board;

  rgbhsv_pix_if #(.CHANNEL_BITS(CB)) pix_ch ();
  rgbhsv_hsv_if #(.CHANNEL_BITS(CB), .HUE_BITS(HB)) hsv_ch ();

  rgb_to_hsv_core #(
    .CHANNEL_BITS(CB),
    .HUE_BITS    (HB)
  ) u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_pix (pix_ch),
    .out_hsv(hsv_ch)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_cnt);
      $display("rgb_to_hsv_core: mismatch");
      $finish;
    end
  end

  // result side: check each transfer, then pick next ready
  always @(posedge clk) begin
    if (rst_n && hsv_ch.valid && hsv_ch.ready)
      board.check_hsv(hsv_ch.hue, hsv_ch.saturation, hsv_ch.brightness);
    if (hold_left != 0) begin
      hold_left    <= hold_left - 1;
      hsv_ch.ready <= 1'b0;
    end else if (holds_started != holds_asked) begin
      holds_started <= holds_started + 1;
      hold_left     <= HOLD_CYCLES;
      hsv_ch.ready  <= 1'b0;
    end else begin
      hsv_ch.ready <= ($urandom_range(99) >= idle_pct);
    end
  end

  task automatic send_pixel(input logic [CB-1:0] r, input logic [CB-1:0] g,
                            input logic [CB-1:0] b);
    while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      pix_ch.valid <= 1'b0;
      @(posedge clk);
    end
    pix_ch.valid <= 1'b1;
    pix_ch.red   <= r;
    pix_ch.green <= g;
    pix_ch.blue  <= b;
    @(posedge clk);
    while (!pix_ch.ready) @(posedge clk);
    board.note_pixel(r, g, b);
  endtask

  function automatic logic [CB-1:0] edge_value();
    case ($urandom_range(3))
      0: return '0;
      1: return CB'(1);
      2: return CB'(254);
      default: return CB'(255);
    endcase
  endfunction

  task automatic send_random(input int count);
    logic [CB-1:0] r;
    logic [CB-1:0] g;
    logic [CB-1:0] b;
    logic [CB-1:0] v;
    for (int i = 0; i < count; i++) begin
      r = CB'($urandom_range(255));
      g = CB'($urandom_range(255));
      b = CB'($urandom_range(255));
      v = CB'($urandom_range(255));
      case ($urandom_range(9))
        5: begin
          r = v;
          g = v;
          b = v;
        end
        // two channels tied, third somewhere below or above
        6: begin
          case ($urandom_range(2))
            0: g = r;
            1: b = g;
            default: b = r;
          endcase
        end
        7: begin
          r = edge_value();
          g = edge_value();
          b = edge_value();
        end
        8: begin
          r = CB'($urandom_range(3));
          g = CB'($urandom_range(3));
          b = CB'($urandom_range(3));
        end
        9: begin
          v = CB'($urandom_range(250, 3));
          r = CB'(v + $urandom_range(4) - 2);
          g = CB'(v + $urandom_range(4) - 2);
          b = CB'(v + $urandom_range(4) - 2);
        end
        default: ;
      endcase
      send_pixel(r, g, b);
    end
  endtask

  initial begin
    clk           = 1'b0;
    rst_n         = 1'b0;
    idle_pct      = 30;
    holds_asked   = 0;
    holds_started = 0;
    hold_left     = 0;
    cycle_cnt     = 0;
    board         = new();
    pix_ch.valid  = 1'b0;
    pix_ch.red    = '0;
    pix_ch.green  = '0;
    pix_ch.blue   = '0;
    hsv_ch.ready  = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // black, white, grey, primaries and secondaries, ties and wrap of the red sector
    send_pixel(8'd0,   8'd0,   8'd0);
    send_pixel(8'd255, 8'd255, 8'd255);
    send_pixel(8'd128, 8'd128, 8'd128);
    send_pixel(8'd1,   8'd1,   8'd1);
    send_pixel(8'd255, 8'd0,   8'd0);
    send_pixel(8'd0,   8'd255, 8'd0);
    send_pixel(8'd0,   8'd0,   8'd255);
    send_pixel(8'd255, 8'd255, 8'd0);
    send_pixel(8'd0,   8'd255, 8'd255);
    send_pixel(8'd255, 8'd0,   8'd255);
    send_pixel(8'd255, 8'd0,   8'd1);
    send_pixel(8'd255, 8'd1,   8'd0);
    send_pixel(8'd1,   8'd0,   8'd0);
    send_pixel(8'd0,   8'd1,   8'd0);
    send_pixel(8'd0,   8'd0,   8'd1);
    send_pixel(8'd254, 8'd255, 8'd255);
    send_pixel(8'd1,   8'd1,   8'd0);
    send_pixel(8'd170, 8'd85,  8'd255);
    send_pixel(8'd255, 8'd128, 8'd255);
    send_pixel(8'd1,   8'd2,   8'd3);
    send_pixel(8'd3,   8'd2,   8'd1);
    send_pixel(8'd200, 8'd100, 8'd150);
    send_pixel(8'd85,  8'd170, 8'd0);

    // long receiver hold while the sender keeps offering pixels
    holds_asked = holds_asked + 1;
    send_random(600);

    // a stretch with no idling on either side
    idle_pct = 0;
    send_random(500);

    idle_pct    = 30;
    holds_asked = holds_asked + 1;
    send_random(600);

    pix_ch.valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("sent %0d pixels (%0d grey, %0d black), checked %0d results",
             board.pixels, board.greys, board.blacks, board.results);
    $display("two long output holds, one stretch at full rate, %0d field errors",
             board.errors);
    if (board.errors == 0) begin
      $display("rgb_to_hsv_core: match");
    end else begin
      $display("rgb_to_hsv_core: mismatch");
    end
    $finish;
  end

endmodule
